/* src/dre_pkg.sv */
`default_nettype none
package dre_pkg;

	typedef enum logic [3:0] {
		PH_HEADER = 4'd0,
		PH_QNAME  = 4'd1,
		PH_QLABEL = 4'd2,
		PH_QPTR   = 4'd3,
		PH_QTAIL  = 4'd4,
		PH_ANAME  = 4'd5,
		PH_ALABEL = 4'd6,
		PH_APTR   = 4'd7,
		PH_AFIXED = 4'd8,
		PH_RDATA  = 4'd9,
		PH_DONE   = 4'd10,
		PH_DRAIN  = 4'd11
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ID_ERR    = 2'd1,
		ST_SERVER    = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	localparam logic [7:0]  PTR_MASK   = 8'hc0;
	localparam logic [3:0]  RCODE_MASK = 4'hf;
	localparam logic [15:0] TYPE_A     = 16'h0001;
	localparam logic [15:0] IPV4_RDLEN = 16'd4;
	localparam logic [15:0] ID_RESET   = 16'h1000;

	localparam logic [15:0] HDR_ID_END    = 16'd1;
	localparam logic [15:0] HDR_FLAGS_END = 16'd3;
	localparam logic [15:0] HDR_AN_END    = 16'd7;
	localparam logic [15:0] HDR_END       = 16'd11;
	localparam logic [15:0] QTAIL_END     = 16'd3;
	localparam logic [15:0] TYPE_END      = 16'd1;
	localparam logic [15:0] FIXED_END     = 16'd9;

	typedef struct packed {
		logic        valid;
		logic [31:0] ip_address;
		logic        address_valid;
		logic        done_res;
		logic [1:0]  status;
		logic [3:0]  response_code;
	} result_t;

endpackage
`default_nettype wire

/* src/dns_response_address_extractor_top.sv */
// Path: a byte accepted into the input register (data_s1) is parsed
// combinationally, and its result is registered in res_q once the output
// is free, so it is offered on the master side from that register.
// Throughput: one byte per cycle while the master side does not stall.
// Reset: arst_n clears the parse state, both valid flags and sets the
// expected ID to 0x1000.
`default_nettype none
module dns_response_address_extractor_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // ip_address[31:0], status[33:32],
	                                        // response_code[37:34], zero[39:38]
	output logic             m_axis_tuser,  // address_valid
	output logic             m_axis_tlast
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;
	logic              out_free;
	logic              advance;
	dre_pkg::result_t  res;
	dre_pkg::result_t  res_q;
	logic              out_valid_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	dre_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.response_code, res_q.status, res_q.ip_address};
	assign m_axis_tuser  = res_q.address_valid;
	assign m_axis_tlast  = res_q.done_res;

endmodule
`default_nettype wire

/* src/dre_parser.sv */
`default_nettype none
module dre_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	output dre_pkg::result_t     result
);

	dre_pkg::phase_t phase_q, phase_n;
	logic [15:0] exp_id_q, exp_id_n;
	logic [15:0] cnt_q, cnt_n;
	logic [15:0] acc_q, acc_n;
	logic [15:0] ans_q, ans_n;
	logic [31:0] shift_q, shift_n;
	logic        rec_q, rec_n;
	logic [1:0]  err_q, err_n;
	logic [3:0]  code_q, code_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= dre_pkg::PH_HEADER;
			exp_id_q <= dre_pkg::ID_RESET;
			cnt_q    <= '0;
			acc_q    <= '0;
			ans_q    <= '0;
			shift_q  <= '0;
			rec_q    <= 1'b0;
			err_q    <= '0;
			code_q   <= '0;
		end else if (en) begin
			phase_q  <= phase_n;
			exp_id_q <= exp_id_n;
			cnt_q    <= cnt_n;
			acc_q    <= acc_n;
			ans_q    <= ans_n;
			shift_q  <= shift_n;
			rec_q    <= rec_n;
			err_q    <= err_n;
			code_q   <= code_n;
		end
	end

	always_comb begin
		logic        emit;
		logic [31:0] addr;
		logic [15:0] dec;
		logic [15:0] ans_dec;
		logic [1:0]  st;
		emit    = 1'b0;
		addr    = '0;
		phase_n  = phase_q;
		exp_id_n = exp_id_q;
		cnt_n    = cnt_q;
		acc_n    = acc_q;
		ans_n    = ans_q;
		shift_n  = shift_q;
		rec_n    = rec_q;
		err_n    = err_q;
		code_n   = code_q;
		dec      = cnt_q - 16'd1;
		ans_dec  = ans_q - 16'd1;
		unique case (phase_q)
			dre_pkg::PH_HEADER: begin
				acc_n = {acc_q[7:0], data_byte};
				if (cnt_q == dre_pkg::HDR_ID_END && acc_n != exp_id_q) begin
					err_n = dre_pkg::ST_ID_ERR;
				end
				if (cnt_q == dre_pkg::HDR_FLAGS_END) begin
					code_n = acc_n[3:0] & dre_pkg::RCODE_MASK;
					if (err_q == dre_pkg::ST_OK && code_n != 4'd0) begin
						err_n = dre_pkg::ST_SERVER;
					end
				end
				if (cnt_q == dre_pkg::HDR_AN_END) begin
					ans_n = acc_n;
				end
				if (cnt_q == dre_pkg::HDR_END) begin
					cnt_n   = '0;
					phase_n = (err_n != dre_pkg::ST_OK) ? dre_pkg::PH_DRAIN
						: dre_pkg::PH_QNAME;
				end else begin
					cnt_n = cnt_q + 16'd1;
				end
			end
			dre_pkg::PH_QNAME, dre_pkg::PH_ANAME: begin
				cnt_n = '0;
				if ((data_byte & dre_pkg::PTR_MASK) == dre_pkg::PTR_MASK) begin
					phase_n = (phase_q == dre_pkg::PH_QNAME) ? dre_pkg::PH_QPTR
						: dre_pkg::PH_APTR;
				end else if (data_byte == 8'd0) begin
					phase_n = (phase_q == dre_pkg::PH_QNAME) ? dre_pkg::PH_QTAIL
						: dre_pkg::PH_AFIXED;
				end else begin
					cnt_n   = {8'd0, data_byte};
					phase_n = (phase_q == dre_pkg::PH_QNAME) ? dre_pkg::PH_QLABEL
						: dre_pkg::PH_ALABEL;
				end
			end
			dre_pkg::PH_QLABEL, dre_pkg::PH_ALABEL: begin
				cnt_n = dec;
				if (dec == 16'd0) begin
					phase_n = (phase_q == dre_pkg::PH_QLABEL) ? dre_pkg::PH_QNAME
						: dre_pkg::PH_ANAME;
				end
			end
			dre_pkg::PH_QPTR: begin
				cnt_n   = '0;
				phase_n = dre_pkg::PH_QTAIL;
			end
			dre_pkg::PH_APTR: begin
				cnt_n   = '0;
				phase_n = dre_pkg::PH_AFIXED;
			end
			dre_pkg::PH_QTAIL: begin
				if (cnt_q == dre_pkg::QTAIL_END) begin
					cnt_n   = '0;
					phase_n = (ans_q == 16'd0) ? dre_pkg::PH_DONE : dre_pkg::PH_ANAME;
				end else begin
					cnt_n = cnt_q + 16'd1;
				end
			end
			dre_pkg::PH_AFIXED: begin
				acc_n = {acc_q[7:0], data_byte};
				if (cnt_q == dre_pkg::TYPE_END) begin
					rec_n = (acc_n == dre_pkg::TYPE_A);
				end
				if (cnt_q == dre_pkg::FIXED_END) begin
					if (acc_n == 16'd0) begin
						ans_n   = ans_dec;
						cnt_n   = '0;
						phase_n = (ans_dec == 16'd0) ? dre_pkg::PH_DONE
							: dre_pkg::PH_ANAME;
					end else begin
						rec_n   = rec_q && (acc_n == dre_pkg::IPV4_RDLEN);
						cnt_n   = acc_n;
						shift_n = '0;
						phase_n = dre_pkg::PH_RDATA;
					end
				end else begin
					cnt_n = cnt_q + 16'd1;
				end
			end
			dre_pkg::PH_RDATA: begin
				shift_n = {shift_q[23:0], data_byte};
				cnt_n   = dec;
				if (dec == 16'd0) begin
					if (rec_q) begin
						emit = 1'b1;
						addr = shift_n;
					end
					ans_n   = ans_dec;
					cnt_n   = '0;
					phase_n = (ans_dec == 16'd0) ? dre_pkg::PH_DONE : dre_pkg::PH_ANAME;
				end
			end
			default: begin
			end
		endcase

		st = err_n;
		if (st == dre_pkg::ST_OK && phase_n != dre_pkg::PH_DONE) begin
			st = dre_pkg::ST_TRUNCATED;
		end

		result.valid         = emit || last_byte;
		result.ip_address    = addr;
		result.address_valid = emit;
		result.done_res      = last_byte;
		result.status        = last_byte ? st : dre_pkg::ST_OK;
		result.response_code = last_byte ? code_n : 4'd0;

		if (last_byte) begin
			exp_id_n = exp_id_q + 16'd1;
			phase_n  = dre_pkg::PH_HEADER;
			cnt_n    = '0;
			acc_n    = '0;
			ans_n    = '0;
			shift_n  = '0;
			rec_n    = 1'b0;
			err_n    = dre_pkg::ST_OK;
			code_n   = '0;
		end
	end

endmodule
`default_nettype wire
